FILE: src/dmad_pkg.sv
// ----------------------------------------------------------------------------
// dmad_pkg
// Shared constants for the moving-average difference unit: window sizes,
// datapath widths and reciprocal constants for the divisions by window size.
// ----------------------------------------------------------------------------
package dmad_pkg;

  localparam int LONG_WINDOW    = 50;
  localparam int SHORT_WINDOW   = 10;
  localparam int AVERAGE_WINDOW = 10;
  localparam int PRICE_BITS     = 24;

  localparam int SHORT_EFF = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;

  // stream widths
  localparam int DIFF_W   = PRICE_BITS + 1;
  localparam int IN_W     = ((PRICE_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((2 * DIFF_W + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - 2 * DIFF_W;
  localparam int USER_W   = 2;

  // price window
  localparam int PTR_W    = $clog2(LONG_WINDOW);
  localparam int CNT_W    = $clog2(LONG_WINDOW + 1);
  localparam int LSUM_W   = PRICE_BITS + $clog2(LONG_WINDOW);
  localparam int SSUM_W   = PRICE_BITS + $clog2(SHORT_EFF);

  // difference window
  localparam int DPTR_W   = (AVERAGE_WINDOW > 1) ? $clog2(AVERAGE_WINDOW) : 1;
  localparam int DCNT_W   = $clog2(AVERAGE_WINDOW + 1);
  localparam int DSUM_W   = DIFF_W + $clog2(AVERAGE_WINDOW);
  localparam int MAG_W    = PRICE_BITS + $clog2(AVERAGE_WINDOW);

  // floor(x / d) = (x * ceil(2^s / d)) >> s for x < 2^n, s = n + clog2(d)
  localparam int L_SHIFT   = LSUM_W + $clog2(LONG_WINDOW);
  localparam int L_MAGIC_W = LSUM_W + 1;
  localparam int L_PROD_W  = LSUM_W + L_MAGIC_W;
  localparam logic [63:0] L_MAGIC =
    ((64'd1 << L_SHIFT) + 64'(LONG_WINDOW) - 64'd1) / 64'(LONG_WINDOW);

  localparam int S_SHIFT   = SSUM_W + $clog2(SHORT_EFF);
  localparam int S_MAGIC_W = SSUM_W + 1;
  localparam int S_PROD_W  = SSUM_W + S_MAGIC_W;
  localparam logic [63:0] S_MAGIC =
    ((64'd1 << S_SHIFT) + 64'(SHORT_EFF) - 64'd1) / 64'(SHORT_EFF);

  localparam int A_SHIFT   = MAG_W + $clog2(AVERAGE_WINDOW);
  localparam int A_MAGIC_W = MAG_W + 1;
  localparam int A_PROD_W  = MAG_W + A_MAGIC_W;
  localparam logic [63:0] A_MAGIC =
    ((64'd1 << A_SHIFT) + 64'(AVERAGE_WINDOW) - 64'd1) / 64'(AVERAGE_WINDOW);

  // position of the sample leaving the short window after reset
  localparam int SPTR_INIT = (LONG_WINDOW - SHORT_EFF) % LONG_WINDOW;

endpackage

FILE: src/dmad_ram.sv
// ----------------------------------------------------------------------------
// dmad_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/dma_moving_average_difference_unit.sv
// ----------------------------------------------------------------------------
// dma_moving_average_difference_unit
// Short-minus-long moving average of a price stream, plus a moving average
// of that difference. Running sums over RAM-backed windows.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------
//  in_     | in  | tdata: price
//  out_    | out | tdata: difference, average_difference; tuser: valid flags
//
//  one beat per cycle sustained while out_tready stays high
//  rate set by the running-sum updates of the price and difference windows,
//  whose ring reads are prefetched from the window RAMs in the cycle before use
//  reset clears counts and sums and presets the pointers; window RAMs need no clearing pass
//  a stalled output fills the bubbles of the pipeline before in_tready drops
// ----------------------------------------------------------------------------
module dma_moving_average_difference_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dmad_pkg::IN_W-1:0]    in_tdata,   // price
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dmad_pkg::OUT_W-1:0]   out_tdata,  // difference, average_difference
  output logic [dmad_pkg::USER_W-1:0]  out_tuser   // difference_valid, average_valid
);
  import dmad_pkg::*;

  localparam int STAGES = 8;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] rdy;

  // stage 0: input beat and price window
  logic [PRICE_BITS-1:0] price0_r;
  logic [PTR_W-1:0]      pos_r, pos_nxt;
  logic [PTR_W-1:0]      sptr_r, sptr_nxt;
  logic [CNT_W-1:0]      pcnt_r;
  logic [LSUM_W-1:0]     lsum_r, lsum_nxt;
  logic [SSUM_W-1:0]     ssum_r, ssum_nxt;
  logic [PRICE_BITS-1:0] ram_l_q, ram_s_q, old_l, old_s;
  logic [PRICE_BITS-1:0] pwr_r;
  logic                  lbyp_r, sbyp_r;
  logic                  fire0, l_full, s_full, dvalid0;

  // stage 1..3
  logic [LSUM_W-1:0]     lsum1_r;
  logic [SSUM_W-1:0]     ssum1_r;
  logic                  dv1_r, dv2_r, dv3_r;
  logic [L_PROD_W-1:0]   lprod2_r, lprod_nxt;
  logic [S_PROD_W-1:0]   sprod2_r, sprod_nxt;
  logic [L_MAGIC_W-1:0]  l_magic_c;
  logic [S_MAGIC_W-1:0]  s_magic_c;
  logic [PRICE_BITS-1:0] lmean, smean;
  logic signed [DIFF_W-1:0] diff3_r;

  // difference window
  logic [DPTR_W-1:0]        dptr_r, dptr_nxt;
  logic [DCNT_W-1:0]        dcnt_r;
  logic signed [DSUM_W-1:0] dsum_r, dsum_nxt;
  logic [DIFF_W-1:0]        ram_d_q, old_d;
  logic [DIFF_W-1:0]        dwr_r;
  logic                     dbyp_r, dupd, d_full;

  // stage 4..7
  logic signed [DIFF_W-1:0] diff4_r, diff5_r, diff6_r;
  logic                     dv4_r, dv5_r, dv6_r;
  logic                     av4_r, av5_r, av6_r;
  logic signed [DSUM_W-1:0] dsum4_r;
  logic [MAG_W-1:0]         mag5_r;
  logic                     neg5_r, neg6_r;
  logic [A_PROD_W-1:0]      aprod6_r, aprod_nxt;
  logic [A_MAGIC_W-1:0]     a_magic_c;
  logic [PRICE_BITS-1:0]    aq;
  logic [DIFF_W-1:0]        aq_ext, avg;
  logic [OUT_W-1:0]         out_tdata_r;
  logic [USER_W-1:0]        out_tuser_r;

  // pipeline flow control
  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];
  assign fire0     = vld_r[0] && rdy[1];

  // price window
  assign l_magic_c = L_MAGIC[L_MAGIC_W-1:0];
  assign s_magic_c = S_MAGIC[S_MAGIC_W-1:0];
  assign a_magic_c = A_MAGIC[A_MAGIC_W-1:0];

  assign old_l   = lbyp_r ? pwr_r : ram_l_q;
  assign old_s   = sbyp_r ? pwr_r : ram_s_q;
  assign l_full  = (pcnt_r == CNT_W'(LONG_WINDOW));
  assign s_full  = (pcnt_r >= CNT_W'(SHORT_EFF));
  assign dvalid0 = (pcnt_r >= CNT_W'(LONG_WINDOW - 1));

  assign lsum_nxt = lsum_r - (l_full ? LSUM_W'(old_l) : '0) + LSUM_W'(price0_r);
  assign ssum_nxt = ssum_r - (s_full ? SSUM_W'(old_s) : '0) + SSUM_W'(price0_r);

  always_comb begin
    pos_nxt  = pos_r;
    sptr_nxt = sptr_r;
    if (fire0) begin
      pos_nxt  = (pos_r == PTR_W'(LONG_WINDOW - 1)) ? '0 : pos_r + 1'b1;
      sptr_nxt = (sptr_r == PTR_W'(LONG_WINDOW - 1)) ? '0 : sptr_r + 1'b1;
    end
  end

  dmad_ram #(.WIDTH(PRICE_BITS), .DEPTH(LONG_WINDOW)) u_ram_long (
    .clk   (clk),
    .we    (fire0),
    .waddr (pos_r),
    .wdata (price0_r),
    .raddr (pos_nxt),
    .rdata (ram_l_q)
  );

  dmad_ram #(.WIDTH(PRICE_BITS), .DEPTH(LONG_WINDOW)) u_ram_short (
    .clk   (clk),
    .we    (fire0),
    .waddr (pos_r),
    .wdata (price0_r),
    .raddr (sptr_nxt),
    .rdata (ram_s_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sptr_r <= PTR_W'(SPTR_INIT);
      pcnt_r <= '0;
      lsum_r <= '0;
      ssum_r <= '0;
      lbyp_r <= 1'b0;
      sbyp_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sptr_r <= sptr_nxt;
      lbyp_r <= fire0 && (pos_nxt == pos_r);
      sbyp_r <= fire0 && (sptr_nxt == pos_r);
      if (fire0) begin
        lsum_r <= lsum_nxt;
        ssum_r <= ssum_nxt;
        if (!l_full) begin
          pcnt_r <= pcnt_r + 1'b1;
        end
      end
    end
  end

  // difference window
  assign dupd   = vld_r[3] && rdy[4] && dv3_r;
  assign old_d  = dbyp_r ? dwr_r : ram_d_q;
  assign d_full = (dcnt_r == DCNT_W'(AVERAGE_WINDOW));

  always_comb begin
    dptr_nxt = dptr_r;
    dsum_nxt = dsum_r;
    if (dupd) begin
      dptr_nxt = (dptr_r == DPTR_W'(AVERAGE_WINDOW - 1)) ? '0 : dptr_r + 1'b1;
    end
    if (dv3_r) begin
      dsum_nxt = dsum_r - (d_full ? DSUM_W'($signed(old_d)) : '0) + DSUM_W'(diff3_r);
    end
  end

  dmad_ram #(.WIDTH(DIFF_W), .DEPTH(AVERAGE_WINDOW)) u_ram_diff (
    .clk   (clk),
    .we    (dupd),
    .waddr (dptr_r),
    .wdata (diff3_r),
    .raddr (dptr_nxt),
    .rdata (ram_d_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dptr_r <= '0;
      dcnt_r <= '0;
      dsum_r <= '0;
      dbyp_r <= 1'b0;
    end else begin
      dptr_r <= dptr_nxt;
      dbyp_r <= dupd && (dptr_nxt == dptr_r);
      if (dupd) begin
        dsum_r <= dsum_nxt;
        if (!d_full) begin
          dcnt_r <= dcnt_r + 1'b1;
        end
      end
    end
  end

  // datapath
  assign lprod_nxt = lsum1_r * l_magic_c;
  assign sprod_nxt = ssum1_r * s_magic_c;
  assign lmean     = lprod2_r[L_SHIFT +: PRICE_BITS];
  assign smean     = sprod2_r[S_SHIFT +: PRICE_BITS];
  assign aprod_nxt = mag5_r * a_magic_c;
  assign aq        = aprod6_r[A_SHIFT +: PRICE_BITS];
  assign aq_ext    = DIFF_W'(aq);
  assign avg       = av6_r ? (neg6_r ? -aq_ext : aq_ext) : '0;

  always_ff @(posedge clk) begin
    if (fire0) begin
      pwr_r <= price0_r;
    end
    if (dupd) begin
      dwr_r <= diff3_r;
    end
    if (rdy[0]) begin
      price0_r <= in_tdata[PRICE_BITS-1:0];
    end
    if (rdy[1]) begin
      lsum1_r <= lsum_nxt;
      ssum1_r <= ssum_nxt;
      dv1_r   <= dvalid0;
    end
    if (rdy[2]) begin
      lprod2_r <= lprod_nxt;
      sprod2_r <= sprod_nxt;
      dv2_r    <= dv1_r;
    end
    if (rdy[3]) begin
      diff3_r <= dv2_r ? $signed(DIFF_W'(smean) - DIFF_W'(lmean)) : '0;
      dv3_r   <= dv2_r;
    end
    if (rdy[4]) begin
      diff4_r <= diff3_r;
      dv4_r   <= dv3_r;
      av4_r   <= dv3_r && (dcnt_r >= DCNT_W'(AVERAGE_WINDOW - 1));
      dsum4_r <= dsum_nxt;
    end
    if (rdy[5]) begin
      diff5_r <= diff4_r;
      dv5_r   <= dv4_r;
      av5_r   <= av4_r;
      neg5_r  <= dsum4_r[DSUM_W-1];
      mag5_r  <= dsum4_r[DSUM_W-1] ? MAG_W'(-dsum4_r) : MAG_W'(dsum4_r);
    end
    if (rdy[6]) begin
      diff6_r  <= diff5_r;
      dv6_r    <= dv5_r;
      av6_r    <= av5_r;
      neg6_r   <= neg5_r;
      aprod6_r <= aprod_nxt;
    end
    if (rdy[7]) begin
      out_tdata_r <= {{OUT_PAD{1'b0}}, avg, diff6_r};
      out_tuser_r <= {av6_r, dv6_r};
    end
  end

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: dv/dma_moving_average_difference_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dma_moving_average_difference_unit_tb
// Drives a price stream into the moving-average difference unit and checks
// every output beat against a cycle-free model of the short and long price
// windows and of the difference window. A short table covers price extremes
// during warm-up, then random segments of noise, flat highs and lows, near-
// constant runs and ramps push the windows through large swings. Both
// channels idle at random, except for one long steady stretch.
// ----------------------------------------------------------------------------
module dma_moving_average_difference_unit_tb;
  import dmad_pkg::*;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int RANDOM_ITEMS  = 1625;
  localparam int QUIET_FIRST   = 500;
  localparam int QUIET_LAST    = 900;
  localparam int DRAIN_CYCLES  = 16;
  localparam int DIRECTED_ROWS = 25;
  localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;

  typedef logic [PRICE_BITS-1:0]    price_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    diff_t difference;
    logic  difference_valid;
    diff_t average_difference;
    logic  average_valid;
  } indicator_t;

  typedef struct packed {
    price_t     price;
    logic       typed;
    indicator_t result;
  } stim_row_t;

  typedef enum logic [2:0] {SEG_NOISE, SEG_HIGH, SEG_LOW, SEG_NEAR, SEG_RAMP} segment_t;

  localparam indicator_t WARMING = '0;

  // all rows fall inside the long-window warm-up, so every result is zero
  localparam stim_row_t WARMUP_TABLE [DIRECTED_ROWS] = '{
    '{24'h000000, 1'b1, WARMING}, '{24'hFFFFFF, 1'b1, WARMING},
    '{24'h000001, 1'b1, WARMING}, '{24'h800000, 1'b1, WARMING},
    '{24'h7FFFFF, 1'b1, WARMING}, '{24'hFFFFFE, 1'b1, WARMING},
    '{24'hAAAAAA, 1'b1, WARMING}, '{24'h555555, 1'b1, WARMING},
    '{24'h000002, 1'b1, WARMING}, '{24'h000004, 1'b1, WARMING},
    '{24'h000010, 1'b1, WARMING}, '{24'h000100, 1'b1, WARMING},
    '{24'h001000, 1'b1, WARMING}, '{24'h010000, 1'b1, WARMING},
    '{24'h100000, 1'b1, WARMING}, '{24'h400000, 1'b1, WARMING},
    '{24'hFFFF00, 1'b1, WARMING}, '{24'h00FFFF, 1'b1, WARMING},
    '{24'h0F0F0F, 1'b1, WARMING}, '{24'hF0F0F0, 1'b1, WARMING},
    '{24'h123456, 1'b1, WARMING}, '{24'hFEDCBA, 1'b1, WARMING},
    '{24'h000000, 1'b1, WARMING}, '{24'hFFFFFF, 1'b1, WARMING},
    '{24'h000000, 1'b1, WARMING}
  };

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic [USER_W-1:0]   out_tuser;

  logic                steady_run;
  logic                row_typed;
  indicator_t          row_result;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;

  // model of the price and difference windows
  price_t              price_hist [LONG_WINDOW];
  int unsigned         price_wr = 0;
  int unsigned         price_seen = 0;
  logic [LSUM_W-1:0]   long_total = '0;
  logic [SSUM_W-1:0]   short_total = '0;
  diff_t               diff_hist [AVERAGE_WINDOW];
  int unsigned         diff_wr = 0;
  int unsigned         diff_seen = 0;
  logic signed [DSUM_W-1:0] diff_total = '0;

  // predicted beats in order of acceptance
  indicator_t          pending_beats [TOTAL_ITEMS];
  int unsigned         beats_in = 0;
  int unsigned         beats_out = 0;

  dma_moving_average_difference_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic indicator_t advance_indicator(input price_t p);
    indicator_t r;
    price_t     short_mean;
    price_t     long_mean;
    r = WARMING;
    if (price_seen >= LONG_WINDOW) long_total -= price_hist[price_wr];
    if (price_seen >= SHORT_EFF)
      short_total -= price_hist[(price_wr + LONG_WINDOW - SHORT_EFF) % LONG_WINDOW];
    price_hist[price_wr] = p;
    price_wr = (price_wr + 1) % LONG_WINDOW;
    long_total += p;
    short_total += p;
    if (price_seen < LONG_WINDOW) price_seen++;
    if (price_seen >= LONG_WINDOW) begin
      short_mean = price_t'(short_total / SSUM_W'(SHORT_EFF));
      long_mean  = price_t'(long_total / LSUM_W'(LONG_WINDOW));
      r.difference = $signed({1'b0, short_mean}) - $signed({1'b0, long_mean});
      r.difference_valid = 1'b1;
      if (diff_seen >= AVERAGE_WINDOW) diff_total -= DSUM_W'(diff_hist[diff_wr]);
      diff_hist[diff_wr] = r.difference;
      diff_wr = (diff_wr + 1) % AVERAGE_WINDOW;
      diff_total += DSUM_W'(r.difference);
      if (diff_seen < AVERAGE_WINDOW) diff_seen++;
      if (diff_seen >= AVERAGE_WINDOW) begin
        // signed division truncates toward zero
        r.average_difference = diff_t'(diff_total / $signed(DSUM_W'(AVERAGE_WINDOW)));
        r.average_valid = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string field, input diff_t want, input diff_t got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // accepted prices feed the model, accepted output beats are checked
  always @(posedge clk) begin
    indicator_t predicted;
    indicator_t want;
    if (rst_n && in_tvalid && in_tready) begin
      predicted = advance_indicator(in_tdata[PRICE_BITS-1:0]);
      pending_beats[beats_in] = row_typed ? row_result : predicted;
      beats_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (beats_out == beats_in) begin
        $display("%0t unexpected beat: expected none actual %h / %b", $time, out_tdata,
                 out_tuser);
        mismatch_count++;
      end else begin
        want = pending_beats[beats_out];
        beats_out++;
        check_field("difference", want.difference, out_tdata[DIFF_W-1:0]);
        check_field("difference_valid", diff_t'(want.difference_valid),
                    diff_t'(out_tuser[0]));
        check_field("average_difference", want.average_difference,
                    out_tdata[2*DIFF_W-1:DIFF_W]);
        check_field("average_valid", diff_t'(want.average_valid), diff_t'(out_tuser[1]));
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && (steady_run || $urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_price(input price_t p, input logic typed, input indicator_t result);
    while (!steady_run && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= IN_W'(p);
    row_typed  <= typed;
    row_result <= result;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    segment_t seg;
    price_t   base;
    price_t   p;
    int       span;
    int       slope;
    int       sent;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    row_typed  <= 1'b0;
    row_result <= WARMING;
    steady_run <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_price(WARMUP_TABLE[i].price, WARMUP_TABLE[i].typed, WARMUP_TABLE[i].result);

    // random segments: flat runs swing the short mean hard against the long one
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg   = segment_t'($urandom_range(4));
      span  = $urandom_range(70, 1);
      base  = price_t'($urandom);
      slope = int'($urandom_range(4096)) - 2048;
      for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        case (seg)
          SEG_NOISE: p = price_t'($urandom);
          SEG_HIGH:  p = '1;
          SEG_LOW:   p = '0;
          SEG_NEAR:  p = base ^ price_t'($urandom_range(255));
          default:   p = base + price_t'(slope * k);
        endcase
        steady_run <= (sent >= QUIET_FIRST && sent < QUIET_LAST);
        send_price(p, 1'b0, WARMING);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (beats_out != beats_in) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
